@@ rtl/bouncing_particle_grid_step_macros.svh @@
// Assertion macros for the particle grid step block.
`ifndef BOUNCING_PARTICLE_GRID_STEP_MACROS_SVH
`define BOUNCING_PARTICLE_GRID_STEP_MACROS_SVH

// Check cons in the same cycle as ante.
`define BPGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BPGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in a later cycle than ante.
`define BPGS_ASSERT_TWO(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ rtl/bpgs_pkg.sv @@
`timescale 1ns / 1ps

package bpgs_pkg;

  localparam int GRID_DIM_DEF = 16;
  localparam int CMD_W        = 2;
  localparam int COORD_W      = 6;
  localparam int DIR_W        = 4;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  typedef struct packed {
    logic shift;
    logic r_top;
    logic r_one;
    logic r_bot;
    logic r_pen;
    logic c_lft;
    logic c_one;
    logic c_rgt;
    logic c_pen;
  } win_ctl_t;

endpackage

@@ rtl/bouncing_particle_grid_step.sv @@
`timescale 1ns / 1ps
// Particle grid step: a GRID_DIM by GRID_DIM grid of 4-bit direction cells.
// Input channel (in_valid/in_ready) carries cmd, row, col, dirs; output
// channel (out_valid/out_ready) returns one beat per input beat with
// cell_dirs and out_of_range.
// Write and read: the state register (and rdata, on a read) take the input
// beat, then S_RESP loads the result into the output register. Tick: every
// cell is read once from the single grid memory, in raster order, and
// rewritten in place from a window of 2*GRID_DIM+1 cells; the result beat
// follows the end of the pass. The one read port of the grid memory bounds
// the length of the pass.
// One item is in work at a time; in_ready is high only when idle.
// Reset: a clearing pass writes zero to every cell, with in_ready low;
// out_valid drops at once.
// A stalled receiver holds the result beat in the output register; the
// next item is still accepted, and its result waits until the register
// frees up.

module bouncing_particle_grid_step #(
  parameter int GRID_DIM = bpgs_pkg::GRID_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpgs_pkg::CMD_W-1:0]   cmd,
  input  logic [bpgs_pkg::COORD_W-1:0] row,
  input  logic [bpgs_pkg::COORD_W-1:0] col,
  input  logic [bpgs_pkg::DIR_W-1:0]   dirs,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpgs_pkg::DIR_W-1:0]   cell_dirs,
  output logic                         out_of_range
);

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_DIM);
  localparam int TW    = $clog2(CELLS + GRID_DIM + 2);
  localparam int LAG   = GRID_DIM + 2;
  localparam int DONE  = CELLS + GRID_DIM + 1;

  localparam logic [RW-1:0] LAST  = RW'(GRID_DIM - 1);
  localparam logic [RW-1:0] PEN   = RW'(GRID_DIM - 2);
  localparam logic [RW-1:0] ONE   = RW'(1);
  localparam logic [AW-1:0] DIM_A = AW'(GRID_DIM);
  localparam logic [bpgs_pkg::COORD_W:0] DIM_C = (bpgs_pkg::COORD_W + 1)'(GRID_DIM);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_TICK, S_RESP} state_t;

  state_t                     state;
  logic [TW-1:0]              t;
  logic [RW-1:0]              cr;
  logic [RW-1:0]              cc;
  logic [AW-1:0]              ca;
  logic                       read_ok;
  logic                       res_oor;
  logic [bpgs_pkg::DIR_W-1:0] mem [CELLS];
  logic [bpgs_pkg::DIR_W-1:0] rdata;

  logic                       accept;
  logic                       in_grid;
  logic                       resp_fire;
  logic [AW-1:0]              cell_addr;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [bpgs_pkg::DIR_W-1:0] wdata;
  logic [bpgs_pkg::DIR_W-1:0] win_next;
  bpgs_pkg::win_ctl_t         win_ctl;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_grid   = ({1'b0, row} < DIM_C) && ({1'b0, col} < DIM_C);
  assign cell_addr = AW'(row) * DIM_A + AW'(col);
  assign resp_fire = (state == S_RESP) && (!out_valid || out_ready);

  always_comb begin
    win_ctl.shift = (state == S_TICK);
    win_ctl.r_top = (cr == '0);
    win_ctl.r_one = (cr == ONE);
    win_ctl.r_bot = (cr == LAST);
    win_ctl.r_pen = (cr == PEN);
    win_ctl.c_lft = (cc == '0);
    win_ctl.c_one = (cc == ONE);
    win_ctl.c_rgt = (cc == LAST);
    win_ctl.c_pen = (cc == PEN);
  end

  bpgs_window #(
    .GRID_DIM(GRID_DIM)
  ) u_window (
    .clk      (clk),
    .ctl      (win_ctl),
    .din      (rdata),
    .next_cell(win_next)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = cell_addr;
    raddr  = cell_addr;
    wdata  = dirs;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = t[AW-1:0];
        wdata  = '0;
      end
      S_IDLE: begin
        if (accept && in_grid) begin
          mem_we = (cmd == bpgs_pkg::CMD_WRITE);
          mem_re = (cmd == bpgs_pkg::CMD_READ);
        end
      end
      S_TICK: begin
        mem_re = (t < TW'(CELLS));
        raddr  = t[AW-1:0];
        mem_we = (t >= TW'(LAG));
        waddr  = ca;
        wdata  = win_next;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      t         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (resp_fire) begin
        out_valid    <= 1'b1;
        cell_dirs    <= read_ok ? rdata : '0;
        out_of_range <= res_oor;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (t == TW'(CELLS - 1)) begin
            t     <= '0;
            state <= S_IDLE;
          end else begin
            t <= t + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            read_ok <= (cmd == bpgs_pkg::CMD_READ) && in_grid;
            res_oor <= ((cmd == bpgs_pkg::CMD_WRITE) || (cmd == bpgs_pkg::CMD_READ)) &&
                       !in_grid;
            if (cmd == bpgs_pkg::CMD_TICK) begin
              t     <= '0;
              cr    <= '0;
              cc    <= '0;
              ca    <= '0;
              state <= S_TICK;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_TICK: begin
          t <= t + 1'b1;
          if (t >= TW'(LAG)) begin
            ca <= ca + 1'b1;
            if (cc == LAST) begin
              cc <= '0;
              cr <= cr + 1'b1;
            end else begin
              cc <= cc + 1'b1;
            end
          end
          if (t == TW'(DONE)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ rtl/bpgs_window.sv @@
`timescale 1ns / 1ps

module bpgs_window #(
  parameter int GRID_DIM = bpgs_pkg::GRID_DIM_DEF
) (
  input  logic                       clk,
  input  bpgs_pkg::win_ctl_t         ctl,
  input  logic [bpgs_pkg::DIR_W-1:0] din,
  output logic [bpgs_pkg::DIR_W-1:0] next_cell
);

  localparam int TAPS = 2 * GRID_DIM + 1;

  logic [bpgs_pkg::DIR_W-1:0] win [TAPS];
  logic [bpgs_pkg::DIR_W-1:0] below;
  logic [bpgs_pkg::DIR_W-1:0] above;
  logic [bpgs_pkg::DIR_W-1:0] left_n;
  logic [bpgs_pkg::DIR_W-1:0] right_n;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win[0] <= din;
      for (int i = 1; i < TAPS; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  assign below   = win[0];
  assign right_n = win[GRID_DIM-1];
  assign left_n  = win[GRID_DIM+1];
  assign above   = win[2*GRID_DIM];

  // gather incoming particles, with bounces off the edges
  always_comb begin
    next_cell[bpgs_pkg::DIR_UP] = !ctl.r_bot &&
        (below[bpgs_pkg::DIR_UP] || (ctl.r_pen && below[bpgs_pkg::DIR_DOWN]));
    next_cell[bpgs_pkg::DIR_DOWN] = !ctl.r_top &&
        (above[bpgs_pkg::DIR_DOWN] || (ctl.r_one && above[bpgs_pkg::DIR_UP]));
    next_cell[bpgs_pkg::DIR_LEFT] = !ctl.c_rgt &&
        (right_n[bpgs_pkg::DIR_LEFT] || (ctl.c_pen && right_n[bpgs_pkg::DIR_RIGHT]));
    next_cell[bpgs_pkg::DIR_RIGHT] = !ctl.c_lft &&
        (left_n[bpgs_pkg::DIR_RIGHT] || (ctl.c_one && left_n[bpgs_pkg::DIR_LEFT]));
  end

endmodule

@@ rtl/bpgs_checker.sv @@
`timescale 1ns / 1ps
`include "bouncing_particle_grid_step_macros.svh"

module bpgs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bpgs_pkg::CMD_W-1:0]   cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpgs_pkg::DIR_W-1:0]   cell_dirs,
  input logic                         out_of_range
);

  `BPGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_dirs) && $stable(out_of_range), "stalled output beat changed")
  `BPGS_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `BPGS_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, cell_dirs == '0, "out-of-range beat carries cell data")
  `BPGS_ASSERT_TWO(a_access_lat, in_valid && in_ready && !out_valid && (cmd != bpgs_pkg::CMD_TICK), out_valid, "access result late")

endmodule

bind bouncing_particle_grid_step bpgs_checker u_bpgs_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID = bpgs_pkg::GRID_DIM_DEF;
  localparam int RANDOM_ITEMS = 1030;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;

  typedef logic [bpgs_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [bpgs_pkg::COORD_W-1:0] coord_t;
  typedef logic [bpgs_pkg::DIR_W-1:0]   dir_t;

  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct {
    dir_t cell_dirs;
    logic out_of_range;
  } grid_beat_t;

  class particle_grid_tracker;
    bit [bpgs_pkg::DIR_W-1:0] cells [GRID][GRID];
    grid_beat_t               expected_beats[$];
    int                       errors;

    function void step_particles();
      bit [bpgs_pkg::DIR_W-1:0] nxt [GRID][GRID];
      bit [bpgs_pkg::DIR_W-1:0] v;
      int                       last;
      last = GRID - 1;
      for (int r = 0; r < GRID; r++)
        for (int c = 0; c < GRID; c++)
          nxt[r][c] = '0;
      for (int r = 0; r < GRID; r++) begin
        for (int c = 0; c < GRID; c++) begin
          v = cells[r][c];
          if (v[bpgs_pkg::DIR_UP]) begin
            if (r == 0) nxt[1][c][bpgs_pkg::DIR_DOWN] = 1'b1;
            else nxt[r-1][c][bpgs_pkg::DIR_UP] = 1'b1;
          end
          if (v[bpgs_pkg::DIR_DOWN]) begin
            if (r == last) nxt[r-1][c][bpgs_pkg::DIR_UP] = 1'b1;
            else nxt[r+1][c][bpgs_pkg::DIR_DOWN] = 1'b1;
          end
          if (v[bpgs_pkg::DIR_LEFT]) begin
            if (c == 0) nxt[r][1][bpgs_pkg::DIR_RIGHT] = 1'b1;
            else nxt[r][c-1][bpgs_pkg::DIR_LEFT] = 1'b1;
          end
          if (v[bpgs_pkg::DIR_RIGHT]) begin
            if (c == last) nxt[r][c-1][bpgs_pkg::DIR_LEFT] = 1'b1;
            else nxt[r][c+1][bpgs_pkg::DIR_RIGHT] = 1'b1;
          end
        end
      end
      for (int r = 0; r < GRID; r++)
        for (int c = 0; c < GRID; c++)
          cells[r][c] = nxt[r][c];
    endfunction

    function void note_accepted(cmd_t c, coord_t r, coord_t k, dir_t d);
      grid_beat_t b;
      bit         in_grid;
      in_grid = (r < GRID) && (k < GRID);
      b.cell_dirs = '0;
      b.out_of_range = 1'b0;
      case (c)
        bpgs_pkg::CMD_WRITE: begin
          if (in_grid) cells[r][k] = d;
          else b.out_of_range = 1'b1;
        end
        bpgs_pkg::CMD_READ: begin
          if (in_grid) b.cell_dirs = cells[r][k];
          else b.out_of_range = 1'b1;
        end
        bpgs_pkg::CMD_TICK: step_particles();
        default: ;
      endcase
      expected_beats.push_back(b);
    endfunction

    function void check_beat(dir_t cd, logic oor);
      grid_beat_t b;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: cell_dirs %h out_of_range %b", cd, oor);
        errors++;
        return;
      end
      b = expected_beats.pop_front();
      if (cd !== b.cell_dirs) begin
        $error("cell_dirs: expected %h, actual %h", b.cell_dirs, cd);
        errors++;
      end
      if (oor !== b.out_of_range) begin
        $error("out_of_range: expected %b, actual %b", b.out_of_range, oor);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  cmd_t   cmd;
  coord_t row;
  coord_t col;
  dir_t   dirs;
  logic   out_valid;
  logic   out_ready;
  dir_t   cell_dirs;
  logic   out_of_range;

  particle_grid_tracker grid_model;
  bit                   idle_on;
  bit                   hold_req;

  bouncing_particle_grid_step i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .row          (row),
    .col          (col),
    .dirs         (dirs),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_dirs    (cell_dirs),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Start and end on a falling edge.
  task automatic push_item(input cmd_t c, input int r, input int k, input int d);
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row <= coord_t'(r);
    col <= coord_t'(k);
    dirs <= dir_t'(d);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grid_model.note_accepted(c, coord_t'(r), coord_t'(k), dir_t'(d));
    @(negedge clk);
  endtask

  function automatic int pick_coord();
    if ($urandom_range(9) < 3) return $urandom_range(1) ? GRID - 1 : 0;
    return $urandom_range(GRID - 1);
  endfunction

  function automatic int pick_outside();
    return $urandom_range(63, GRID);
  endfunction

  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 38);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) grid_model.check_beat(cell_dirs, out_of_range);
  end

  initial begin
    int p;
    int n;
    int r;
    int k;
    grid_model = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = bpgs_pkg::CMD_WRITE;
    row = '0;
    col = '0;
    dirs = '0;
    out_ready = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_item(bpgs_pkg::CMD_READ, 0, 0, 15);
    push_item(bpgs_pkg::CMD_WRITE, 0, 0, 5);
    push_item(bpgs_pkg::CMD_WRITE, 0, GRID - 1, 9);
    push_item(bpgs_pkg::CMD_WRITE, GRID - 1, 0, 6);
    push_item(bpgs_pkg::CMD_WRITE, GRID - 1, GRID - 1, 10);
    push_item(bpgs_pkg::CMD_WRITE, 7, 8, 15);
    push_item(bpgs_pkg::CMD_WRITE, 3, 3, 0);
    push_item(bpgs_pkg::CMD_WRITE, GRID, 0, 15);
    push_item(bpgs_pkg::CMD_WRITE, 63, 63, 15);
    push_item(bpgs_pkg::CMD_WRITE, 0, 63, 3);
    push_item(bpgs_pkg::CMD_READ, 63, 0, 0);
    push_item(bpgs_pkg::CMD_READ, 5, GRID, 0);
    push_item(CMD_UNUSED, 63, 63, 15);
    push_item(bpgs_pkg::CMD_READ, 7, 8, 0);
    push_item(bpgs_pkg::CMD_TICK, 0, 0, 0);
    push_item(bpgs_pkg::CMD_READ, 1, 0, 0);
    push_item(bpgs_pkg::CMD_READ, 0, 1, 0);
    push_item(bpgs_pkg::CMD_READ, 1, GRID - 1, 0);
    push_item(bpgs_pkg::CMD_READ, GRID - 2, 0, 0);
    push_item(bpgs_pkg::CMD_READ, GRID - 1, GRID - 2, 0);
    push_item(bpgs_pkg::CMD_READ, 6, 8, 0);
    push_item(bpgs_pkg::CMD_TICK, 63, 42, 10);
    push_item(bpgs_pkg::CMD_READ, 0, 0, 0);
    push_item(bpgs_pkg::CMD_READ, 7, 8, 0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == 300) idle_on = 1'b0;
      if (n == 460) idle_on = 1'b1;
      if (n == 600) hold_req = 1'b1;
      p = $urandom_range(99);
      r = pick_coord();
      k = pick_coord();
      if (p < 40) begin
        push_item(bpgs_pkg::CMD_WRITE, r, k, $urandom_range(15));
      end else if (p < 70) begin
        push_item(bpgs_pkg::CMD_READ, r, k, $urandom_range(15));
      end else if (p < 79) begin
        push_item(bpgs_pkg::CMD_TICK, $urandom_range(63), $urandom_range(63),
                  $urandom_range(15));
      end else if (p < 89) begin
        case ($urandom_range(2))
          0: r = pick_outside();
          1: k = pick_outside();
          default: begin
            r = pick_outside();
            k = pick_outside();
          end
        endcase
        push_item($urandom_range(1) ? bpgs_pkg::CMD_READ : bpgs_pkg::CMD_WRITE, r, k,
                  $urandom_range(15));
      end else if (p < 94) begin
        push_item(CMD_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(15));
      end else begin
        r = $urandom_range(63);
        k = $urandom_range(63);
        push_item($urandom_range(1) ? bpgs_pkg::CMD_READ : bpgs_pkg::CMD_WRITE, r, k,
                  $urandom_range(15));
      end
      n++;
    end
    in_valid <= 1'b0;

    while (grid_model.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (grid_model.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bpgs_pkg.sv
rtl/bpgs_window.sv
rtl/bouncing_particle_grid_step.sv
rtl/bpgs_checker.sv
tb/tb_top.sv
